/* hw/rtl/positional_insert_delete_array_unit_macros.svh */
// Assertion helpers shared by the list unit modules
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_UNIT_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define PIDA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list unit assertion failed");

// Next-cycle implication, disabled while reset is held
`define PIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list unit assertion failed");

`endif

/* hw/rtl/pida_pkg.sv */
`default_nettype none

package pida_pkg;

  // Default sizing
  localparam int DEPTH_DEF      = 128;
  localparam int DATA_WIDTH_DEF = 32;

  // Field widths
  localparam int MODE_W     = 2;
  localparam int POS_W      = 8;
  localparam int VAL_W      = 32;
  localparam int ST_W       = 2;
  localparam int CNT_W      = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic req_load;
    logic st_load;
    logic rd_src;
    logic rd_pos;
    logic wr_shift;
    logic wr_word;
    logic cur_inc;
    logic cur_dec;
    logic cnt_clear;
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;
  } pida_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ST_W-1:0]   check;
    logic              ins_more;
    logic              del_more;
  } pida_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/pida_dp.sv */
`default_nettype none
`include "positional_insert_delete_array_unit_macros.svh"

module pida_dp #(
  parameter int DEPTH      = pida_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = pida_pkg::DATA_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire [pida_pkg::MODE_W-1:0]     in_mode,
  input  wire [pida_pkg::POS_W-1:0]      in_position,
  input  wire signed [pida_pkg::VAL_W-1:0] in_value,
  input  wire pida_pkg::pida_cmd_t       cmd,
  output pida_pkg::pida_stat_t           stat,
  output logic [pida_pkg::ST_W-1:0]      out_status,
  output logic signed [pida_pkg::VAL_W-1:0] out_read_value,
  output logic [pida_pkg::CNT_W-1:0]     out_count
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > pida_pkg::POS_W) ? CW + 1 : pida_pkg::POS_W + 1;
  localparam int EXTW = (DATA_WIDTH > pida_pkg::VAL_W) ? DATA_WIDTH : pida_pkg::VAL_W;

  // List storage
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // Request and control registers
  logic [pida_pkg::MODE_W-1:0] mode_r;
  logic [pida_pkg::POS_W-1:0]  pos_r;
  logic [DATA_WIDTH-1:0]       word_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               cur_r, cur_nxt;
  logic [pida_pkg::ST_W-1:0]   st_r;

  logic [CMPW-1:0] pos_x, cnt_x, cur_x, depth_x, src_x;
  logic [EXTW-1:0] word_ext, rd_ext;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic            mem_we, mem_re;
  logic [pida_pkg::ST_W-1:0] check;

  assign pos_x   = CMPW'(pos_r);
  assign cnt_x   = CMPW'(count_r);
  assign cur_x   = CMPW'(cur_r);
  assign depth_x = CMPW'(DEPTH);

  // Classify the held request against the current count
  always_comb begin
    check = pida_pkg::ST_OK;
    case (mode_r)
      pida_pkg::MODE_INSERT: begin
        if (pos_x > cnt_x) begin
          check = pida_pkg::ST_INVALID;
        end else if (cnt_x >= depth_x) begin
          check = pida_pkg::ST_FULL;
        end
      end
      pida_pkg::MODE_DELETE, pida_pkg::MODE_READ: begin
        if (pos_x >= cnt_x) begin
          check = pida_pkg::ST_INVALID;
        end
      end
      default: check = pida_pkg::ST_OK;
    endcase
  end

  assign stat.mode     = mode_r;
  assign stat.check    = check;
  assign stat.ins_more = (cur_x > pos_x);
  assign stat.del_more = ((cur_x + CMPW'(1)) < cnt_x);

  // Hold the status as classified before the count moves
  always_ff @(posedge clk) begin
    if (cmd.st_load) begin
      st_r <= check;
    end
  end

  // Memory addressing: shift source sits one below (insert) or above (delete) the cursor
  assign src_x   = (mode_r == pida_pkg::MODE_INSERT) ? (cur_x - CMPW'(1)) : (cur_x + CMPW'(1));
  assign rd_addr = cmd.rd_pos ? pos_x[AW-1:0] : src_x[AW-1:0];
  assign wr_addr = cmd.wr_word ? pos_x[AW-1:0] : cur_x[AW-1:0];
  assign wr_data = cmd.wr_word ? word_r : rd_data_r;
  assign mem_we  = cmd.wr_shift | cmd.wr_word;
  assign mem_re  = cmd.rd_src | cmd.rd_pos;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Capture the request
  assign word_ext = EXTW'(in_value);

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      word_r <= word_ext[DATA_WIDTH-1:0];
    end
  end

  // Step the shift cursor
  always_comb begin
    cur_nxt = cur_r;
    if (cmd.req_load) begin
      cur_nxt = (in_mode == pida_pkg::MODE_INSERT) ? count_r : CW'(in_position);
    end else if (cmd.cur_inc) begin
      cur_nxt = cur_r + CW'(1);
    end else if (cmd.cur_dec) begin
      cur_nxt = cur_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Update the entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clear) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Load the result register
  assign rd_ext = EXTW'($signed(rd_data_r));

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= st_r;
      out_count  <= pida_pkg::CNT_W'(count_r);
      if ((mode_r == pida_pkg::MODE_READ) && (st_r == pida_pkg::ST_OK)) begin
        out_read_value <= rd_ext[pida_pkg::VAL_W-1:0];
      end else begin
        out_read_value <= '0;
      end
    end
  end

  `PIDA_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, cnt_x <= depth_x)
  `PIDA_ASSERT_IMPL(a_shift_in_range, clk, rst_n, cmd.wr_shift, cur_x < depth_x)
  `PIDA_ASSERT_IMPL(a_inc_not_full, clk, rst_n, cmd.cnt_inc, cnt_x < depth_x)

endmodule

`default_nettype wire

/* hw/rtl/pida_ctrl.sv */
`default_nettype none
`include "positional_insert_delete_array_unit_macros.svh"

module pida_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  input  wire pida_pkg::pida_stat_t stat,
  output pida_pkg::pida_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WR    = 3'd2;
  localparam logic [2:0] S_RDW   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Sequence one request through check, shift and result
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.st_load = 1'b1;
        if (stat.mode == pida_pkg::MODE_CLEAR) begin
          cmd.cnt_clear = 1'b1;
          state_nxt     = S_DONE;
        end else if (stat.check != pida_pkg::ST_OK) begin
          state_nxt = S_DONE;
        end else begin
          case (stat.mode)
            pida_pkg::MODE_INSERT: begin
              if (stat.ins_more) begin
                cmd.rd_src = 1'b1;
                state_nxt  = S_WR;
              end else begin
                cmd.wr_word = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_nxt   = S_DONE;
              end
            end
            pida_pkg::MODE_DELETE: begin
              if (stat.del_more) begin
                cmd.rd_src = 1'b1;
                state_nxt  = S_WR;
              end else begin
                cmd.cnt_dec = 1'b1;
                state_nxt   = S_DONE;
              end
            end
            default: begin
              cmd.rd_pos = 1'b1;
              state_nxt  = S_RDW;
            end
          endcase
        end
      end
      S_WR: begin
        cmd.wr_shift = 1'b1;
        if (stat.mode == pida_pkg::MODE_INSERT) begin
          cmd.cur_dec = 1'b1;
        end else begin
          cmd.cur_inc = 1'b1;
        end
        state_nxt = S_CHECK;
      end
      S_RDW: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Track the pending result
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PIDA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `PIDA_ASSERT_IMPL(a_wr_after_check, clk, rst_n, state_r == S_WR, $past(state_r) == S_CHECK)
  `PIDA_ASSERT_NEXT(a_done_holds, clk, rst_n,
    (state_r == S_DONE) && out_valid_r && !out_tready, state_r == S_DONE)

endmodule

`default_nettype wire

/* hw/rtl/positional_insert_delete_array_unit.sv */
// Steps: an accepted request passes S_CHECK, then S_DONE, where the result is registered;
// a read also passes S_RDW, and an insert or delete alternates S_CHECK and S_WR for
// each moved entry (one memory read and one memory write per moved entry).
// Flow: one request in flight; the next is taken only after the result is registered
// and the controller is back in S_IDLE, and S_DONE holds while the output is stalled.
// Reset: synchronous active-low rst_n empties the list.
`default_nettype none

module positional_insert_delete_array_unit #(
  parameter int DEPTH      = pida_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = pida_pkg::DATA_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [7:0] position, [39:8] value
  input  wire [pida_pkg::IN_DATA_W-1:0]       in_tdata,
  // [1:0] mode
  input  wire [pida_pkg::MODE_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [31:0] read_value, [39:32] count
  output logic [pida_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [1:0] status
  output logic [pida_pkg::ST_W-1:0]           out_tuser
);

  pida_pkg::pida_cmd_t  cmd;
  pida_pkg::pida_stat_t stat;

  logic signed [pida_pkg::VAL_W-1:0] in_value;
  logic signed [pida_pkg::VAL_W-1:0] res_read_value;
  logic [pida_pkg::CNT_W-1:0]        res_count;

  // Unpack the request and pack the result
  assign in_value  = $signed(in_tdata[pida_pkg::IN_DATA_W-1:pida_pkg::POS_W]);
  assign out_tdata = {res_count, res_read_value};

  pida_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pida_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_tuser),
    .in_position    (in_tdata[pida_pkg::POS_W-1:0]),
    .in_value       (in_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_tuser),
    .out_read_value (res_read_value),
    .out_count      (res_count)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;
  import pida_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int TOTAL_ITEMS  = 520;
  localparam int QUIET_AT     = 440;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 120;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int FILL_ITEMS   = LIST_DEPTH + 16;

  // One result as the block returns it
  typedef struct {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] count;
  } list_result_t;

  // Shadow copy of the list, with the results it owes
  class list_shadow;
    logic [VAL_W-1:0] list_words [LIST_DEPTH];
    int unsigned      list_len;
    list_result_t     due_results [$];
    int unsigned      error_count;

    function new();
      list_len    = 0;
      error_count = 0;
      foreach (list_words[i]) list_words[i] = '0;
    endfunction

    function void report(string msg);
      $display("tb_top: mismatch: %s", msg);
      error_count++;
    endfunction

    // Apply an accepted request and queue the result it owes
    function void note_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] word);
      list_result_t r;
      int unsigned  i;
      r.status     = ST_OK;
      r.read_value = '0;
      case (mode)
        MODE_CLEAR: begin
          list_len = 0;
        end
        MODE_INSERT: begin
          if (pos > list_len) begin
            r.status = ST_INVALID;
          end else if (list_len >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
            list_words[pos] = word;
            list_len++;
          end
        end
        MODE_DELETE: begin
          if (pos >= list_len) begin
            r.status = ST_INVALID;
          end else begin
            for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
            list_len--;
          end
        end
        default: begin
          if (pos >= list_len) r.status = ST_INVALID;
          else r.read_value = list_words[pos];
        end
      endcase
      r.count = list_len[CNT_W-1:0];
      due_results.push_back(r);
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_result(logic [ST_W-1:0] status, logic [VAL_W-1:0] rd,
                               logic [CNT_W-1:0] cnt);
      list_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result with none owed: status %0d value %h count %0d",
                         status, rd, cnt));
        return;
      end
      want = due_results.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, wanted %0d", status, want.status));
      if (rd !== want.read_value)
        report($sformatf("read_value %h, wanted %h", rd, want.read_value));
      if (cnt !== want.count)
        report($sformatf("count %0d, wanted %0d", cnt, want.count));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [ST_W-1:0]       out_tuser;

  list_shadow  shadow = new();
  bit          quiet_phase;
  int unsigned sent_count;
  int unsigned results_seen;
  int unsigned cycle_count;

  positional_insert_delete_array_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Word for a request, with the extremes drawn often
  function automatic logic [VAL_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Idle for a burst now and then, then offer one request until it is taken
  task automatic issue(logic [MODE_W-1:0] mode, int unsigned pos, logic [VAL_W-1:0] word);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {word, pos[POS_W-1:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.note_request(mode, pos[POS_W-1:0], word);
    sent_count++;
  endtask

  // Result side: check accepted results and stall in bursts
  initial begin : result_side
    int unsigned stall_left;
    bit          long_done;
    stall_left = 0;
    long_done  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        shadow.check_result(out_tuser, out_tdata[VAL_W-1:0], out_tdata[VAL_W+CNT_W-1:VAL_W]);
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!long_done && results_seen >= HOLD_AT) begin
        // Hold off long enough for the request side to back up
        long_done  = 1'b1;
        stall_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // Request side
  initial begin : request_side
    int unsigned      kind;
    int unsigned      fills;
    int unsigned      n;
    int unsigned      r;
    int unsigned      hi;
    int unsigned      lo_bad;
    int unsigned      p;
    logic [MODE_W-1:0] m;
    fills        = 0;
    quiet_phase  = 1'b0;
    sent_count   = 0;
    results_seen = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_CLEAR;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, edges of position and word, shifts both ways
    issue(MODE_READ,   0, '0);
    issue(MODE_DELETE, 0, '1);
    issue(MODE_INSERT, 1, 32'h1234_5678);
    issue(MODE_INSERT, 0, 32'h7FFF_FFFF);
    issue(MODE_INSERT, 0, 32'h8000_0000);
    issue(MODE_INSERT, 2, 32'h0000_0000);
    issue(MODE_INSERT, 1, 32'hFFFF_FFFF);
    issue(MODE_INSERT, 5, 32'h0BAD_0BAD);
    issue(MODE_READ,   0, '0);
    issue(MODE_READ,   1, '0);
    issue(MODE_READ,   2, '0);
    issue(MODE_READ,   3, '0);
    issue(MODE_READ,   4, '0);
    issue(MODE_READ,   LIST_DEPTH, '1);
    issue(MODE_DELETE, 1, '0);
    issue(MODE_DELETE, 2, '0);
    issue(MODE_DELETE, 2, '0);
    issue(MODE_READ,   0, '0);
    issue(MODE_READ,   1, '0);
    issue(MODE_CLEAR,  LIST_DEPTH, '1);
    issue(MODE_READ,   0, '0);
    issue(MODE_INSERT, 0, 32'h5555_5555);
    issue(MODE_INSERT, 1, 32'hAAAA_AAAA);
    issue(MODE_READ,   1, '0);

    // Random: list builds, mixed bursts, noise, and a full list now and then
    kind = 0;
    while (sent_count < TOTAL_ITEMS) begin
      if (sent_count >= QUIET_AT) quiet_phase = 1'b1;
      if (fills < 2 && sent_count + FILL_ITEMS < TOTAL_ITEMS &&
          (fills == 0 || $urandom_range(0, 19) == 0)) kind = 0;
      else kind = $urandom_range(1, 9);
      case (kind)
        0: begin
          // Fill to the top, then push against it
          fills++;
          issue(MODE_CLEAR, $urandom_range(0, LIST_DEPTH), pick_word());
          while (shadow.list_len < LIST_DEPTH) issue(MODE_INSERT, shadow.list_len, pick_word());
          issue(MODE_INSERT, LIST_DEPTH, pick_word());
          issue(MODE_INSERT, $urandom_range(0, LIST_DEPTH), pick_word());
          issue(MODE_READ,   LIST_DEPTH - 1, pick_word());
          issue(MODE_READ,   $urandom_range(0, LIST_DEPTH - 1), pick_word());
          issue(MODE_READ,   LIST_DEPTH, pick_word());
          issue(MODE_DELETE, 0, pick_word());
          issue(MODE_INSERT, 0, pick_word());
          issue(MODE_DELETE, LIST_DEPTH - 1, pick_word());
          issue(MODE_DELETE, LIST_DEPTH - 1, pick_word());
        end
        1: begin
          // Fresh list built from random positions
          issue(MODE_CLEAR, $urandom_range(0, LIST_DEPTH), pick_word());
          n = $urandom_range(1, 12);
          repeat (n) issue(MODE_INSERT, $urandom_range(0, shadow.list_len), pick_word());
        end
        8, 9: begin
          // Noise
          n = $urandom_range(1, 4);
          repeat (n) begin
            m = MODE_W'($urandom_range(0, 3));
            issue(m, $urandom_range(0, LIST_DEPTH), $urandom);
          end
        end
        default: begin
          // Mixed burst, mostly at valid positions
          n = $urandom_range(1, 10);
          repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 5) m = MODE_CLEAR;
            else if (r < 40) m = MODE_INSERT;
            else if (r < 65) m = MODE_DELETE;
            else m = MODE_READ;
            hi     = (m == MODE_INSERT) ? shadow.list_len : shadow.list_len - 1;
            lo_bad = (m == MODE_INSERT) ? shadow.list_len + 1 : shadow.list_len;
            if ($urandom_range(0, 99) < 85 && (m == MODE_INSERT || shadow.list_len > 0))
              p = $urandom_range(0, hi);
            else if (lo_bad <= LIST_DEPTH)
              p = $urandom_range(lo_bad, LIST_DEPTH);
            else
              p = $urandom_range(0, LIST_DEPTH);
            issue(m, p, pick_word());
          end
        end
      endcase
    end
    in_tvalid <= 1'b0;

    // Drain, then give the block time to show anything extra
    while (shadow.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* positional_insert_delete_array_unit.f */
+incdir+hw/rtl
hw/rtl/pida_pkg.sv
hw/rtl/pida_dp.sv
hw/rtl/pida_ctrl.sv
hw/rtl/positional_insert_delete_array_unit.sv
tb/sv/tb_top.sv
